@@ design/vdle_pkg.sv @@
// Shared types and constants for the vector display list engine.
`default_nettype none

package vdle_pkg;

   localparam int STACK_DEPTH = 4;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [15:0] LIST_BASE   = 16'h4000;
   localparam logic [15:0] WORD_STEP   = 16'h0002;
   localparam logic [15:0] DWORD_STEP  = 16'h0004;

   localparam logic signed [13:0] MIRROR_ORIGIN = 14'sd1024;
   localparam logic signed [13:0] Y_ORIGIN      = 14'sd1130;
   localparam logic signed [31:0] SCREEN_OFS    = 32'sd17000;

   localparam logic [3:0] SCALE_MAX   = 4'd9;
   localparam logic [3:0] OP_HALT     = 4'h0;
   localparam logic [3:0] OP_LONG_MIN = 4'h1;
   localparam logic [3:0] OP_LONG_MAX = 4'h9;
   localparam logic [3:0] OP_ABS      = 4'hA;
   localparam logic [3:0] OP_HALT_ALT = 4'hB;
   localparam logic [3:0] OP_CALL     = 4'hC;
   localparam logic [3:0] OP_RET      = 4'hD;
   localparam logic [3:0] OP_JUMP     = 4'hE;
   localparam logic [3:0] OP_SHORT    = 4'hF;

   typedef struct packed {
      logic        new_list;
      logic [15:0] first_word;
      logic [15:0] second_word;
   } vdle_req_type;

   typedef struct packed {
      logic               draw_valid;
      logic signed [31:0] x_start;
      logic signed [31:0] y_start;
      logic signed [31:0] x_end;
      logic signed [31:0] y_end;
      logic [6:0]         intensity;
      logic [15:0]        next_address;
      logic               list_done;
      logic signed [15:0] length_total;
   } vdle_rsp_type;

endpackage

`default_nettype wire

@@ design/vector_display_list_engine_unit.sv @@
// Vector display list engine: executes one display list instruction per request.
//
// Usage:
//   The host presents the two words fetched at the last reported next_address
//   on the req_ channel (req_valid / req_stall). Each accepted request yields
//   exactly one response on the rsp_ channel (rsp_valid / rsp_stall) carrying
//   the drawn segment, if any, the next fetch address, the halt flag and the
//   running length. Set new_list on the first request of a list.
//   Requests are registered at the input and results in the response register.
//   Throughput: one request per cycle while rsp_stall is low; the whole
//   instruction is executed combinationally between the input register and
//   the response register, and the list state (address, stack, position,
//   scale, length) updates with it, so the following request sees it at once.
//   When the receiver stalls, the response holds; one further request waits in
//   the input register and req_stall rises only when both are full.
//   csr_write_enable writes mirror_enable (cocktail flip); write it while idle.
//   Synchronous reset clears both registers' valid flags, mirror_enable and the
//   list state except the stack entries; the first request can be taken at once.
`default_nettype none

module vector_display_list_engine_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire vdle_pkg::vdle_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output vdle_pkg::vdle_rsp_type     rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data
);
   import vdle_pkg::*;

   function automatic logic signed [31:0] screen_x(input logic signed [19:0] p);
      logic signed [19:0] adj;
      logic signed [31:0] w;
      adj = p + $signed({18'b0, p[19], p[19]});
      w   = {{12{adj[19]}}, adj};
      w   = w >>> 2;
      return (w <<< 5) - SCREEN_OFS;
   endfunction

   function automatic logic signed [31:0] screen_y(input logic signed [19:0] p);
      logic signed [19:0] adj;
      logic signed [31:0] w;
      adj = p + $signed({18'b0, p[19], p[19]});
      w   = {{12{adj[19]}}, adj};
      w   = w >>> 2;
      return SCREEN_OFS - (w <<< 5);
   endfunction

   logic                     in_vld_ff, in_vld_in;
   vdle_req_type             in_req_ff, in_req_in;
   logic                     out_vld_ff, out_vld_in;
   vdle_rsp_type             out_rsp_ff, out_rsp_in;
   logic                     mirror_ff;

   logic [15:0]              fetch_ff, fetch_in;
   logic [15:0]              stack_ff [STACK_DEPTH];
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic [3:0]               scale_ff, scale_in;
   logic signed [19:0]       beam_x_ff, beam_x_in;
   logic signed [19:0]       beam_y_ff, beam_y_in;
   logic signed [15:0]       len_ff, len_in;
   logic                     push;

   logic                     exec;
   logic [15:0]              w1, w2;
   logic [3:0]               op;
   logic [15:0]              eff_fetch, addr2, addr4, target;
   logic [DEPTH_W-1:0]       eff_depth, depth_dec;
   logic [3:0]               eff_scale;
   logic signed [19:0]       eff_x, eff_y;
   logic signed [15:0]       eff_len;

   logic                     is_long;
   logic [11:0]              mag_x, mag_y;
   logic                     neg_x, neg_y;
   logic [3:0]               base, zval, scale_sum;
   logic signed [4:0]        s_eff;
   logic [3:0]               sh;
   logic signed [13:0]       xr, yr, dx, dy;
   logic signed [16:0]       len_sum;
   logic signed [15:0]       len_sat;
   logic signed [19:0]       nx, ny;
   logic signed [13:0]       ax, ay, ty;

   assign exec      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !exec;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_rsp_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_req_in = in_req_ff;
      if (req_valid && !req_stall) begin
         in_vld_in = 1'b1;
         in_req_in = req_data;
      end else if (exec) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = exec ? 1'b1 : (out_vld_ff && rsp_stall);
   end

   // list state as seen by this instruction
   assign w1        = in_req_ff.first_word;
   assign w2        = in_req_ff.second_word;
   assign op        = w1[15:12];
   assign eff_fetch = in_req_ff.new_list ? LIST_BASE : fetch_ff;
   assign eff_depth = in_req_ff.new_list ? '0 : depth_ff;
   assign eff_scale = in_req_ff.new_list ? '0 : scale_ff;
   assign eff_x     = in_req_ff.new_list ? '0 : beam_x_ff;
   assign eff_y     = in_req_ff.new_list ? '0 : beam_y_ff;
   assign eff_len   = in_req_ff.new_list ? '0 : len_ff;
   assign addr2     = eff_fetch + WORD_STEP;
   assign addr4     = eff_fetch + DWORD_STEP;
   assign target    = LIST_BASE + {w1[14:0] & 15'h0fff, 1'b0};
   assign depth_dec = eff_depth - DEPTH_W'(1);
   assign is_long   = (op >= OP_LONG_MIN) && (op <= OP_LONG_MAX);

   // relative vector datapath
   always_comb begin
      if (is_long) begin
         mag_y = {w1[9:0], 2'b00};
         mag_x = {w2[9:0], 2'b00};
         neg_y = w1[10];
         neg_x = w2[10];
         base  = op;
         zval  = w2[15:12];
      end else begin
         mag_y = {w1[9:8], 10'b0};
         mag_x = {w1[1:0], 10'b0};
         neg_y = w1[10];
         neg_x = w1[2];
         base  = 4'd2 + {2'b00, w1[3], w1[11]};
         zval  = w1[7:4];
      end
      xr = (neg_x ^ mirror_ff) ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x});
      yr = (neg_y ^ mirror_ff) ? -$signed({2'b00, mag_y}) : $signed({2'b00, mag_y});
      scale_sum = eff_scale + base;
      if (scale_sum > SCALE_MAX) begin
         s_eff = -5'sd1;
         sh    = 4'd10;
      end else begin
         s_eff = $signed({1'b0, scale_sum});
         sh    = SCALE_MAX - scale_sum;
      end
      dx = xr >>> sh;
      dy = yr >>> sh;
      len_sum = {eff_len[15], eff_len} + {{12{s_eff[4]}}, s_eff};
      if (len_sum[16] != len_sum[15]) begin
         len_sat = len_sum[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         len_sat = len_sum[15:0];
      end
      nx = eff_x + {{6{dx[13]}}, dx};
      ny = eff_y - {{6{dy[13]}}, dy};
      // absolute move
      ax = {{2{w2[11]}}, w2[11:0]};
      ay = {{2{w1[11]}}, w1[11:0]};
      if (mirror_ff) begin
         ax = MIRROR_ORIGIN - ax;
         ay = MIRROR_ORIGIN - ay;
      end
      ty = Y_ORIGIN - ay;
   end

   always_comb begin
      fetch_in   = fetch_ff;
      depth_in   = depth_ff;
      scale_in   = scale_ff;
      beam_x_in  = beam_x_ff;
      beam_y_in  = beam_y_ff;
      len_in     = len_ff;
      push       = 1'b0;
      out_rsp_in = '0;
      if (exec) begin
         fetch_in  = addr2;
         depth_in  = eff_depth;
         scale_in  = eff_scale;
         beam_x_in = eff_x;
         beam_y_in = eff_y;
         len_in    = eff_len;
         priority if (op == OP_HALT || op == OP_HALT_ALT) begin
            out_rsp_in.list_done = 1'b1;
         end else if (is_long || op == OP_SHORT) begin
            if (is_long) begin
               fetch_in = addr4;
            end
            len_in    = len_sat;
            beam_x_in = nx;
            beam_y_in = ny;
            out_rsp_in.draw_valid = 1'b1;
            out_rsp_in.x_start    = screen_x(eff_x);
            out_rsp_in.y_start    = screen_y(eff_y);
            out_rsp_in.x_end      = screen_x(nx);
            out_rsp_in.y_end      = screen_y(ny);
            out_rsp_in.intensity  = {zval, 3'b000};
         end else if (op == OP_ABS) begin
            fetch_in  = addr4;
            scale_in  = w2[15:12];
            beam_x_in = {{4{ax[13]}}, ax, 2'b00};
            beam_y_in = {{4{ty[13]}}, ty, 2'b00};
         end else if (op == OP_CALL) begin
            if (eff_depth >= DEPTH_W'(STACK_DEPTH)) begin
               out_rsp_in.list_done = 1'b1;
               depth_in = '0;
            end else begin
               push     = 1'b1;
               depth_in = eff_depth + DEPTH_W'(1);
               fetch_in = target;
            end
         end else if (op == OP_RET) begin
            if (eff_depth == '0) begin
               out_rsp_in.list_done = 1'b1;
            end else begin
               depth_in = depth_dec;
               fetch_in = stack_ff[depth_dec[IDX_W-1:0]];
            end
         end else begin
            fetch_in = target;
         end
         out_rsp_in.next_address = fetch_in;
         out_rsp_in.length_total = len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         mirror_ff  <= 1'b0;
         fetch_ff   <= LIST_BASE;
         depth_ff   <= '0;
         scale_ff   <= '0;
         beam_x_ff  <= '0;
         beam_y_ff  <= '0;
         len_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_write_enable) begin
            mirror_ff <= csr_write_data;
         end
         fetch_ff   <= fetch_in;
         depth_ff   <= depth_in;
         scale_ff   <= scale_in;
         beam_x_ff  <= beam_x_in;
         beam_y_ff  <= beam_y_in;
         len_ff     <= len_in;
      end
   end

   // payload registers and return stack
   always_ff @(posedge clock) begin
      in_req_ff <= in_req_in;
      if (exec) begin
         out_rsp_ff <= out_rsp_in;
      end
      if (push) begin
         stack_ff[eff_depth[IDX_W-1:0]] <= addr2;
      end
   end

endmodule

`default_nettype wire

@@ design/vdle_checker.sv @@
// Port-level checks for the vector display list engine, bound to the top level.
`default_nettype none

module vdle_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire vdle_pkg::vdle_req_type req_data,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire vdle_pkg::vdle_rsp_type rsp_data,
   input wire logic                   csr_write_enable,
   input wire logic                   csr_write_data
);
   import vdle_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a segment is never reported together with a halt, and idle fields are zero
   a_draw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.draw_valid |->
         rsp_data.x_start == 0 && rsp_data.y_start == 0 && rsp_data.x_end == 0 &&
         rsp_data.y_end == 0 && rsp_data.intensity == 0)
      else $error("segment fields set without a draw");

   a_draw_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.draw_valid |-> !rsp_data.list_done &&
         rsp_data.intensity[2:0] == 3'b000)
      else $error("draw response with halt or bad intensity");

   // fetch addresses stay word aligned
   a_addr_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.next_address[0])
      else $error("odd fetch address");

endmodule

bind vector_display_list_engine_unit vdle_checker u_vdle_checker (.*);

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for vector_display_list_engine_unit: directed and random display lists.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vdle_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 3;
   localparam int PHASE_QUOTA    = 406;
   localparam int DRIFT_STEPS    = 135;
   localparam int PRINT_LIMIT    = 200;

   class list_engine_scoreboard;
      bit           mirror;
      logic [15:0]  fetch_addr;
      logic [15:0]  ret_stack [STACK_DEPTH];
      int           depth;
      logic [3:0]   scale;
      logic [19:0]  beam_x;
      logic [19:0]  beam_y;
      int           length_sum;
      vdle_rsp_type expected_results [$];
      int           errors;

      function void clear_list();
         fetch_addr = LIST_BASE;
         foreach (ret_stack[i]) ret_stack[i] = '0;
         depth      = 0;
         scale      = '0;
         beam_x     = '0;
         beam_y     = '0;
         length_sum = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // relative move: deltas in quarter units, x grows and y shrinks by the delta
      function void draw_segment(longint xr, longint yr, logic [3:0] base, logic [3:0] z,
                                 inout vdle_rsp_type r);
         logic [3:0] s4;
         int         s;
         int         sh;
         longint     dx, dy, x0, y0, x1, y1, total;
         s4 = scale + base;
         s  = (s4 > SCALE_MAX) ? -1 : int'(s4);
         sh = int'(SCALE_MAX) - s;
         if (mirror) begin
            xr = -xr;
            yr = -yr;
         end
         dx = xr >>> sh;
         dy = yr >>> sh;
         total = longint'(length_sum) + s;
         if (total > 32767) total = 32767;
         if (total < -32768) total = -32768;
         length_sum = int'(total);
         x0 = signed'(beam_x);
         y0 = signed'(beam_y);
         beam_x = 20'(x0 + dx);
         beam_y = 20'(y0 - dy);
         x1 = signed'(beam_x);
         y1 = signed'(beam_y);
         r.draw_valid = 1'b1;
         r.x_start    = 32'((x0 / 4) * 32 - SCREEN_OFS);
         r.y_start    = 32'(SCREEN_OFS - (y0 / 4) * 32);
         r.x_end      = 32'((x1 / 4) * 32 - SCREEN_OFS);
         r.y_end      = 32'(SCREEN_OFS - (y1 / 4) * 32);
         r.intensity  = {z, 3'b000};
      endfunction

      function void note_request(vdle_req_type q);
         vdle_rsp_type r;
         logic [3:0]   op;
         logic [3:0]   base;
         logic [15:0]  target;
         longint       xv, yv;
         bit           done;
         r      = '0;
         done   = 1'b0;
         op     = q.first_word[15:12];
         target = LIST_BASE + {q.first_word[11:0], 1'b0};
         if (q.new_list) clear_list();
         fetch_addr += WORD_STEP;
         case (op)
            OP_HALT, OP_HALT_ALT: begin
               done = 1'b1;
            end
            OP_SHORT: begin
               yv = longint'({q.first_word[9:8], 8'h00}) * 4;
               xv = longint'({q.first_word[1:0], 8'h00}) * 4;
               base = 4'd2 + {2'b00, q.first_word[3], 1'b0} + {3'b000, q.first_word[11]};
               if (q.first_word[10]) yv = -yv;
               if (q.first_word[2]) xv = -xv;
               draw_segment(xv, yv, base, q.first_word[7:4], r);
            end
            OP_ABS: begin
               xv = signed'(q.second_word[11:0]);
               yv = signed'(q.first_word[11:0]);
               fetch_addr += WORD_STEP;
               if (mirror) begin
                  xv = MIRROR_ORIGIN - xv;
                  yv = MIRROR_ORIGIN - yv;
               end
               scale  = q.second_word[15:12];
               beam_x = 20'(xv * 4);
               beam_y = 20'((Y_ORIGIN - yv) * 4);
            end
            OP_CALL: begin
               if (depth >= STACK_DEPTH) begin
                  done  = 1'b1;
                  depth = 0;
               end else begin
                  ret_stack[depth] = fetch_addr;
                  depth++;
                  fetch_addr = target;
               end
            end
            OP_RET: begin
               if (depth == 0) begin
                  done = 1'b1;
               end else begin
                  depth--;
                  fetch_addr = ret_stack[depth];
               end
            end
            OP_JUMP: begin
               fetch_addr = target;
            end
            default: begin
               // long vector, opcodes 1..9
               yv = longint'(q.first_word[9:0]) * 4;
               xv = longint'(q.second_word[9:0]) * 4;
               fetch_addr += WORD_STEP;
               if (q.first_word[10]) yv = -yv;
               if (q.second_word[10]) xv = -xv;
               draw_segment(xv, yv, op, q.second_word[15:12], r);
            end
         endcase
         r.next_address = fetch_addr;
         r.list_done    = done;
         r.length_total = 16'(length_sum);
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         if (errors < PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
         errors++;
      endtask

      task compare_field(string what, longint got, longint want);
         if (got != want) report_mismatch(what, got, want);
      endtask

      task check_response(vdle_rsp_type got);
         vdle_rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing outstanding", 0, 0);
            return;
         end
         want = expected_results.pop_front();
         compare_field("draw_valid", got.draw_valid, want.draw_valid);
         compare_field("x_start", got.x_start, want.x_start);
         compare_field("y_start", got.y_start, want.y_start);
         compare_field("x_end", got.x_end, want.x_end);
         compare_field("y_end", got.y_end, want.y_end);
         compare_field("intensity", got.intensity, want.intensity);
         compare_field("next_address", got.next_address, want.next_address);
         compare_field("list_done", got.list_done, want.list_done);
         compare_field("length_total", got.length_total, want.length_total);
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   vdle_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   vdle_rsp_type rsp_data;
   logic         csr_write_enable;
   logic         csr_write_data;

   list_engine_scoreboard sb;
   bit quiet;
   bit hold_request;
   int requests_sent;
   int idle_cycles;

   vector_display_list_engine_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sampled mid-cycle: these values hold through the next rising edge
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 40) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   function automatic logic [3:0] vector_opcode();
      if ($urandom_range(0, 2) == 0) return OP_SHORT;
      return 4'($urandom_range(OP_LONG_MIN, OP_LONG_MAX));
   endfunction

   function automatic logic [3:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return vector_opcode();
      if (roll < 70) return OP_ABS;
      if (roll < 79) return OP_CALL;
      if (roll < 88) return OP_RET;
      if (roll < 94) return OP_JUMP;
      if (roll < 97) return OP_HALT;
      return OP_HALT_ALT;
   endfunction

   task automatic send_request(input bit fresh, input logic [15:0] w1, input logic [15:0] w2);
      vdle_req_type q;
      q.new_list    = fresh;
      q.first_word  = w1;
      q.second_word = w2;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data  <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_mirror(input bit value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.mirror = value;
   endtask

   task automatic run_directed();
      send_request(1'b1, {OP_ABS, 12'h7FF}, 16'h9800);
      send_request(1'b0, {OP_LONG_MAX, 12'h3FF}, 16'hF3FF);
      send_request(1'b0, {OP_LONG_MIN, 12'h7FF}, 16'h07FF);
      send_request(1'b0, {OP_SHORT, 12'hFFF}, 16'h0000);
      send_request(1'b0, {OP_SHORT, 12'h000}, 16'hFFFF);
      send_request(1'b0, {OP_HALT, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_HALT_ALT, 12'hFFF}, 16'hFFFF);
      send_request(1'b0, {OP_JUMP, 12'hFFF}, 16'h0000);
      send_request(1'b0, {OP_JUMP, 12'h000}, 16'h0000);
      // fill the return stack, then overflow it
      send_request(1'b0, {OP_CALL, 12'h123}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'hFFF}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'h555}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'hAAA}, 16'h0000);
      send_request(1'b0, {OP_RET, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'h010}, 16'h0000);
      send_request(1'b0, {OP_CALL, 12'h020}, 16'h0000);
      send_request(1'b0, {OP_RET, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_RET, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_RET, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_ABS, 12'h000}, 16'h0000);
      send_request(1'b0, {OP_LONG_MAX, 12'h000}, 16'h0000);
      // effective scale past 9 falls back to -1
      send_request(1'b0, {OP_ABS, 12'h123}, 16'h3456);
      send_request(1'b0, {OP_LONG_MAX, 12'h5A5}, 16'hA5A5);
   endtask

   task automatic run_phase(input bit with_drift, input bit with_hold, input bit with_pause,
                            input bit last_phase);
      int start;
      int len;
      int k;
      int i;
      bit xs;
      bit ys;
      bit paused;
      start  = requests_sent;
      paused = 1'b0;
      if (with_hold) hold_request = 1'b1;
      if (with_drift) begin
         // max-length vectors in one direction until the beam wraps
         xs = 1'($urandom);
         ys = 1'($urandom);
         send_request(1'b1, {OP_ABS, 12'($urandom)}, {4'h0, 12'($urandom)});
         for (i = 0; i < DRIFT_STEPS; i++)
            send_request(1'b0, {OP_LONG_MAX, 1'($urandom), ys, 10'h3FF},
                         {4'($urandom), 1'($urandom), xs, 10'h3FF});
      end
      while (requests_sent - start < PHASE_QUOTA) begin
         if (last_phase && requests_sent - start > PHASE_QUOTA / 2) quiet = 1'b1;
         if (with_pause && !paused && requests_sent - start >= PHASE_QUOTA / 2) begin
            drain_results();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0: begin
               k = $urandom_range(1, 5);
               send_request(1'b1, {OP_ABS, 12'($urandom)}, 16'($urandom));
               for (i = 0; i < k; i++) begin
                  send_request(1'b0, {OP_CALL, 12'($urandom)}, 16'($urandom));
                  repeat ($urandom_range(0, 2))
                     send_request(1'b0, {vector_opcode(), 12'($urandom)}, 16'($urandom));
               end
               for (i = 0; i <= k; i++)
                  send_request(1'b0, {OP_RET, 12'($urandom)}, 16'($urandom));
            end
            1: begin
               repeat (8)
                  send_request($urandom_range(0, 3) == 0, 16'($urandom), 16'($urandom));
            end
            default: begin
               len = $urandom_range(3, 24);
               for (i = 0; i < len; i++)
                  send_request(i == 0, {pick_opcode(), 12'($urandom)}, 16'($urandom));
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int p;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      quiet            = 1'b0;
      hold_request     = 1'b0;
      requests_sent    = 0;
      idle_cycles      = 0;
      sb = new;
      sb.clear_list();
      sb.mirror = 1'b0;
      sb.errors = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_mirror(1'b0);
      run_directed();
      for (p = 0; p < 4; p++) begin
         write_mirror(p % 2 == 0);
         run_phase(p % 2 == 0, p == 0, p == 1, p == 3);
      end
      drain_results();
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

`default_nettype wire
